// File: rtl/core/mwpc_pkg.sv
// Shared types, constants and register indexes for the mask window point classifier.
package mwpc_pkg;

  // Image size limits
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  // Field widths fixed by the interface
  localparam int MASK_W  = 8;
  localparam int SIZE_W  = 11;
  localparam int PIX_W   = 10;
  localparam int CLASS_W = 3;

  // Derived widths
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT + 2);
  localparam int CMP_W   = SIZE_W + 2;
  localparam int ENTRY_W = MASK_W + 1;
  localparam int PAIR_W  = 2 * ENTRY_W;
  localparam int WIN_N   = 9;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = SIZE_W;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INSIDE_LEVEL = 2'd2;

  localparam logic [SIZE_W-1:0] RESET_WIDTH  = 11'd640;
  localparam logic [SIZE_W-1:0] RESET_HEIGHT = 11'd480;
  localparam logic [MASK_W-1:0] RESET_LEVEL  = 8'd64;

  // Neighbor count thresholds
  localparam logic [3:0] MIN_OUTER = 4'd2;
  localparam logic [3:0] MIN_INNER = 4'd4;
  localparam logic [3:0] ALL_INNER = 4'd8;

  // Pixel classes
  localparam logic [CLASS_W-1:0] CLASS_INVALID  = 3'd0;
  localparam logic [CLASS_W-1:0] CLASS_BOUNDARY = 3'd1;
  localparam logic [CLASS_W-1:0] CLASS_INTERIOR = 3'd2;
  localparam logic [CLASS_W-1:0] CLASS_OUTSIDE  = 3'd3;
  localparam logic [CLASS_W-1:0] CLASS_INSIDE   = 3'd4;

  typedef struct packed {
    logic [MASK_W-1:0] mask_value;
    logic              point_valid;
    logic              is_padding;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0]   pixel_row;
    logic [PIX_W-1:0]   pixel_col;
    logic [CLASS_W-1:0] pixel_class;
    logic               last_pixel;
  } out_item_t;

  // Which sides of the target pixel lie outside the image
  typedef struct packed {
    logic at_top;
    logic at_bottom;
    logic at_left;
    logic at_right;
  } border_t;

  // One step of work for the back part
  typedef struct packed {
    logic [COL_W-1:0]   addr;
    logic [ENTRY_W-1:0] entry;
    logic               emit;
    logic               use_pre;
    border_t            border;
    logic [PIX_W-1:0]   row;
    logic [PIX_W-1:0]   col;
    logic               last;
  } cmd_t;

endpackage

// File: rtl/core/mwpc_ram.sv
// Generic simple dual-port RAM with read-first registered read.
module mwpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and read ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/mwpc_front.sv
// Front part: config registers, raster counters and per-item command build.
module mwpc_front import mwpc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  in_item_t              in_data,
  input  logic                  q_full,
  output logic                  in_stall,
  output logic                  q_push,
  output cmd_t                  q_cmd,
  output logic [MASK_W-1:0]     inside_level
);

  logic [SIZE_W-1:0] width_r, height_r;
  logic [MASK_W-1:0] level_r;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;

  logic [CMP_W-1:0] wx, hx, cx, rx, r1, trx, tcx, c1;
  logic             wrap, pre, post, emit, last;

  // Effective image size: zero acts as one, clamp to maximum
  always_comb begin
    if (width_r == '0) begin
      wx = CMP_W'(1);
    end else if (CMP_W'(width_r) > CMP_W'(MAX_WIDTH)) begin
      wx = CMP_W'(MAX_WIDTH);
    end else begin
      wx = CMP_W'(width_r);
    end
    if (height_r == '0) begin
      hx = CMP_W'(1);
    end else if (CMP_W'(height_r) > CMP_W'(MAX_HEIGHT)) begin
      hx = CMP_W'(MAX_HEIGHT);
    end else begin
      hx = CMP_W'(height_r);
    end
  end

  // Resolve position of the incoming item and which pixel it completes
  always_comb begin
    wrap = CMP_W'(col_r) >= wx;
    cx   = wrap ? '0 : CMP_W'(col_r);
    r1   = wrap ? CMP_W'(row_r) + CMP_W'(1) : CMP_W'(row_r);
    rx   = (r1 > hx + CMP_W'(1)) ? '0 : r1;
    pre  = (cx == '0) && (rx >= CMP_W'(2)) && ((rx - CMP_W'(2)) < hx);
    post = (cx >= CMP_W'(1)) && (rx >= CMP_W'(1)) && ((rx - CMP_W'(1)) < hx);
    trx  = pre ? rx - CMP_W'(2) : rx - CMP_W'(1);
    tcx  = pre ? wx - CMP_W'(1) : cx - CMP_W'(1);
    emit = pre || post;
    last = emit && (trx == hx - CMP_W'(1)) && (tcx == wx - CMP_W'(1));
    c1   = cx + CMP_W'(1);
  end

  // Advance counters: restart after the final pixel, wrap at row end
  always_comb begin
    if (last) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (c1 >= wx) begin
      col_nxt = '0;
      row_nxt = ROW_W'(rx + CMP_W'(1));
    end else begin
      col_nxt = COL_W'(c1);
      row_nxt = ROW_W'(rx);
    end
  end

  // Build the command for the back part
  always_comb begin
    q_cmd.addr             = COL_W'(cx);
    q_cmd.entry            = in_data.is_padding ? '0
                                                : {in_data.point_valid, in_data.mask_value};
    q_cmd.emit             = emit;
    q_cmd.use_pre          = pre;
    q_cmd.border.at_top    = (trx == '0);
    q_cmd.border.at_bottom = (trx == hx - CMP_W'(1));
    q_cmd.border.at_left   = (tcx == '0);
    q_cmd.border.at_right  = (tcx == wx - CMP_W'(1));
    q_cmd.row              = PIX_W'(trx);
    q_cmd.col              = PIX_W'(tcx);
    q_cmd.last             = last;
  end

  assign in_stall     = q_full;
  assign q_push       = in_valid && !q_full;
  assign inside_level = level_r;

  // Config writes; a size change restarts the frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RESET_WIDTH;
      height_r <= RESET_HEIGHT;
      level_r  <= RESET_LEVEL;
      col_r    <= '0;
      row_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH: begin
          width_r <= cfg_data;
          col_r   <= '0;
          row_r   <= '0;
        end
        REG_IMAGE_HEIGHT: begin
          height_r <= cfg_data;
          col_r    <= '0;
          row_r    <= '0;
        end
        REG_INSIDE_LEVEL: begin
          level_r <= cfg_data[MASK_W-1:0];
        end
        default: begin
        end
      endcase
    end else if (q_push) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

// File: rtl/core/mwpc_queue.sv
// Short command queue between the front and back parts.
module mwpc_queue import mwpc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic full,
  output logic not_empty,
  output cmd_t head_cmd
);

  cmd_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   count_r, count_nxt;

  assign full      = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head_cmd  = mem_r[rd_ptr_r];

  // Track fill level
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Store items
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

endmodule

// File: rtl/core/mwpc_back.sv
// Back part: line stores, 3x3 window, classification and output register.
module mwpc_back import mwpc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [MASK_W-1:0] inside_level,
  input  logic              q_not_empty,
  input  cmd_t              q_cmd,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data
);

  logic                           b1_valid_r;
  cmd_t                           b1_cmd_r;
  logic                           b1_fwd_r;
  logic [PAIR_W-1:0]              b1_fwd_data_r;
  logic [WIN_N-1:0][ENTRY_W-1:0]  win_r, win_nxt, win_cls;
  logic                           out_valid_r;
  out_item_t                      out_data_r;

  logic [PAIR_W-1:0]  rd_pair, pair, wr_pair;
  logic [ENTRY_W-1:0] above, center;
  logic               out_free, exec;
  logic [CLASS_W-1:0] cls;

  // Count inner neighbors and pick the class
  function automatic logic [CLASS_W-1:0] classify(
    input logic [WIN_N-1:0][ENTRY_W-1:0] win,
    input border_t                       brd,
    input logic [MASK_W-1:0]             level
  );
    logic [3:0]         inner;
    logic               outside;
    logic [CLASS_W-1:0] res;
    inner = '0;
    for (int dy = 0; dy < 3; dy++) begin
      for (int dx = 0; dx < 3; dx++) begin
        outside = (dy == 0 && brd.at_top) || (dy == 2 && brd.at_bottom) ||
                  (dx == 0 && brd.at_left) || (dx == 2 && brd.at_right);
        if (!(dy == 1 && dx == 1) && !outside &&
            (win[dy*3+dx][MASK_W-1:0] > level)) begin
          inner = inner + 4'd1;
        end
      end
    end
    if (!win[4][MASK_W]) begin
      res = CLASS_INVALID;
    end else if (win[4][MASK_W-1:0] <= level) begin
      res = CLASS_OUTSIDE;
    end else if ((ALL_INNER - inner >= MIN_OUTER) && (inner >= MIN_INNER)) begin
      res = CLASS_BOUNDARY;
    end else if (inner == ALL_INNER) begin
      res = CLASS_INTERIOR;
    end else begin
      res = CLASS_INSIDE;
    end
    return res;
  endfunction

  // Handshake between stages
  assign out_free = !out_valid_r || !out_stall;
  assign exec     = b1_valid_r && (!b1_cmd_r.emit || out_free);
  assign q_pop    = q_not_empty && (!b1_valid_r || exec);

  // Line store pair: above in the upper half, center in the lower half
  mwpc_ram #(
    .WIDTH(PAIR_W),
    .DEPTH(MAX_WIDTH)
  ) u_line_ram (
    .clk  (clk),
    .we   (exec),
    .waddr(b1_cmd_r.addr),
    .wdata(wr_pair),
    .re   (q_pop),
    .raddr(q_cmd.addr),
    .rdata(rd_pair)
  );

  // Take forwarded data when the previous item wrote this address
  always_comb begin
    pair    = b1_fwd_r ? b1_fwd_data_r : rd_pair;
    above   = pair[PAIR_W-1:ENTRY_W];
    center  = pair[ENTRY_W-1:0];
    wr_pair = {center, b1_cmd_r.entry};
  end

  // Shift the window by one column
  always_comb begin
    win_nxt[0] = win_r[1];
    win_nxt[1] = win_r[2];
    win_nxt[2] = above;
    win_nxt[3] = win_r[4];
    win_nxt[4] = win_r[5];
    win_nxt[5] = center;
    win_nxt[6] = win_r[7];
    win_nxt[7] = win_r[8];
    win_nxt[8] = b1_cmd_r.entry;
    win_cls    = b1_cmd_r.use_pre ? win_r : win_nxt;
    cls        = classify(win_cls, b1_cmd_r.border, inside_level);
  end

  // Load the execute stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_valid_r <= 1'b0;
    end else if (q_pop) begin
      b1_valid_r <= 1'b1;
    end else if (exec) begin
      b1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      b1_cmd_r      <= q_cmd;
      b1_fwd_r      <= exec && (q_cmd.addr == b1_cmd_r.addr);
      b1_fwd_data_r <= wr_pair;
    end
  end

  // Advance the window
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (exec) begin
      win_r <= win_nxt;
    end
  end

  // Output register: load a result, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec && b1_cmd_r.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec && b1_cmd_r.emit) begin
      out_data_r.pixel_row   <= b1_cmd_r.row;
      out_data_r.pixel_col   <= b1_cmd_r.col;
      out_data_r.pixel_class <= cls;
      out_data_r.last_pixel  <= b1_cmd_r.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/core/mask_window_point_classifier.sv
// Top level: 3x3 mask window classifier of raster pixels with point-valid flags.
// Throughput: one item per cycle; the front takes an item each cycle while the queue has room.
// Path: an item that completes a result passes the queue, the execute stage and the output register.
// Results trail the input by one row plus one pixel; feed width+1 padding items per frame.
// Reset: counters clear, width 640, height 480, inside level 64, window zero.
// Line store contents are not cleared by reset; no clearing pass is run.
module mask_window_point_classifier import mwpc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data
);

  logic              q_full, q_push, q_pop, q_not_empty;
  cmd_t              push_cmd, head_cmd;
  logic [MASK_W-1:0] inside_level;

  // Accept items and resolve positions
  mwpc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_data     (in_data),
    .q_full      (q_full),
    .in_stall    (in_stall),
    .q_push      (q_push),
    .q_cmd       (push_cmd),
    .inside_level(inside_level)
  );

  // Decouple front and back
  mwpc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .full     (q_full),
    .not_empty(q_not_empty),
    .head_cmd (head_cmd)
  );

  // Window update and classification
  mwpc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .inside_level(inside_level),
    .q_not_empty (q_not_empty),
    .q_cmd       (head_cmd),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule
